>>> design/lfs_pkg.sv
// shared types and constants for the lagrange fractional shift block
`default_nettype none
package lfs_pkg;

	// configuration register indexes
	localparam logic REG_POINTS = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// reset values of the configuration registers
	localparam logic [2:0] POINTS_RESET = 3'd4;
	localparam logic [8:0] HEIGHT_RESET = 9'd256;

	// store depth and the largest usable height
	localparam int unsigned MAX_HEIGHT = 256;
	localparam logic [8:0] HEIGHT_MAX = 9'd256;

	// interpolation orders
	localparam logic [2:0] PTS_NEAREST = 3'd1;
	localparam logic [2:0] PTS_LINEAR  = 3'd2;
	localparam logic [2:0] PTS_QUAD    = 3'd3;
	localparam logic [2:0] PTS_CUBIC   = 3'd4;

	// entries in the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [2:0] points;
		logic [8:0] height;
	} cfg_t;

	// one classified request as it travels from front to back
	typedef struct packed {
		logic               is_load;
		logic               zero;
		logic        [7:0]  row;
		logic signed [15:0] sample;
		logic        [7:0]  frac;
		logic        [15:0] fsq;
		logic signed [10:0] base;
		logic        [2:0]  pts;
		logic        [8:0]  height;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

>>> design/lfs_front.sv
// front part: accepts requests, forms base row, fraction and early-out flag
`default_nettype none
module lfs_front
	import lfs_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire logic               push,
	output logic                    full,
	input  wire logic               req_type,
	input  wire logic        [7:0]  row_index,
	input  wire logic signed [15:0] sample_value,
	input  wire logic signed [15:0] kick_offset,
	input  wire q_stat_t            qs,
	output logic                    fr_push,
	output job_t                    fr_job
);

	logic               valid_s1;
	job_t               job_s1;
	job_t               nxt;
	logic               accept;
	logic        [2:0]  pts_n;
	logic        [8:0]  hc;
	logic signed [17:0] pos;
	logic        [7:0]  jd;
	logic               half_off;

	always_comb begin
		priority if (cfg.points == 3'd0) begin
			pts_n = PTS_NEAREST;
		end else if (cfg.points > PTS_CUBIC) begin
			pts_n = PTS_CUBIC;
		end else begin
			pts_n = cfg.points;
		end
	end

	assign hc       = (cfg.height > HEIGHT_MAX) ? HEIGHT_MAX : cfg.height;
	assign pos      = $signed({2'b00, hc[8:1], 8'h00}) + 18'(kick_offset);
	assign jd       = pos[15:8];
	// centre tap sits one row back for three and four points
	assign half_off = (pts_n >= PTS_QUAD);

	always_comb begin
		nxt.is_load = (req_type == 1'b0);
		nxt.zero    = pos[17] || ({1'b0, jd} >= hc);
		nxt.row     = row_index;
		nxt.sample  = sample_value;
		nxt.frac    = pos[7:0];
		nxt.fsq     = {8'h00, pos[7:0]} * {8'h00, pos[7:0]};
		nxt.base    = $signed({3'b000, row_index}) + $signed({3'b000, jd})
			- $signed({10'b0, half_off}) - $signed({3'b000, hc[8:1]});
		nxt.pts     = pts_n;
		nxt.height  = hc;
	end

	assign full    = valid_s1 && qs.full;
	assign accept  = push && !full;
	assign fr_push = valid_s1 && !qs.full;
	assign fr_job  = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fr_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

>>> design/lfs_queue.sv
// short job queue between front and back
`default_nettype none
module lfs_queue
	import lfs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    wr_en,
	input  wire job_t    wr_job,
	input  wire logic    rd_en,
	output job_t         rd_job,
	output q_stat_t      stat
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_job     = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule
`default_nettype wire

>>> design/lfs_back.sv
// back part: column store, shared multiplier sequencer, rounding and result register
`default_nettype none
module lfs_back
	import lfs_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire job_t               head,
	input  wire q_stat_t            qs,
	output logic                    q_pop,
	input  wire logic               pop,
	output logic                    empty,
	output logic signed [15:0]      shifted_value
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WGT  = 3'd1;
	localparam logic [2:0] ST_MAC  = 3'd2;
	localparam logic [2:0] ST_RND  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	localparam logic signed [47:0] HALF_DEN = 48'sd50331648;
	localparam logic signed [22:0] T_HI     = 23'sd98303;
	localparam logic signed [22:0] T_LO     = -23'sd98304;
	localparam logic signed [22:0] T_OFF    = 23'sd98304;
	localparam logic        [17:0] U_MAX    = 18'd196607;
	localparam logic        [18:0] RECIP3   = 19'd349526;

	logic        [2:0]  state_q;
	logic        [1:0]  tap_q;
	job_t               cur_q;
	logic signed [29:0] weight_q;
	logic signed [47:0] acc_q;
	logic               inr_q;
	logic        [17:0] u_q;
	logic signed [15:0] res_q;
	logic signed [15:0] out_q;
	logic               out_valid_q;

	logic signed [15:0] mem [MAX_HEIGHT];
	logic signed [15:0] rdata_q;
	logic               mem_we;
	logic        [7:0]  raddr;

	logic signed [17:0] fsq18;
	logic signed [17:0] f256;
	logic signed [17:0] pa;
	logic signed [17:0] pb;
	logic signed [17:0] pc;
	logic signed [11:0] fk;
	logic signed [25:0] pw;
	logic signed [11:0] kw;
	logic signed [29:0] mul_a;
	logic signed [15:0] mul_b;
	logic signed [45:0] mul_p;
	logic signed [10:0] src;
	logic               src_in;
	logic               last_tap;
	logic signed [47:0] rsum;
	logic signed [22:0] tq;
	logic        [36:0] dprod;
	logic        [15:0] quo;
	logic               out_pop;
	logic               slot_free;
	logic               out_load;

	// tap factors: f*(f-256), f*(f+256) and f^2-65536
	assign fsq18 = $signed({2'b00, cur_q.fsq});
	assign f256  = $signed({2'b00, cur_q.frac, 8'h00});
	assign pa    = fsq18 - f256;
	assign pc    = fsq18 + f256;
	assign pb    = fsq18 - 18'sd65536;
	assign fk    = $signed({4'b0000, cur_q.frac});

	always_comb begin
		pw = 26'sd16777216;
		kw = 12'sd6;
		unique case (cur_q.pts)
			PTS_NEAREST: begin
				pw = 26'sd16777216;
				kw = 12'sd6;
			end
			PTS_LINEAR: begin
				kw = 12'sd6;
				if (tap_q == 2'd0) begin
					pw = $signed({1'b0, 9'd256 - {1'b0, cur_q.frac}, 16'h0000});
				end else begin
					pw = $signed({2'b00, cur_q.frac, 16'h0000});
				end
			end
			PTS_QUAD: begin
				unique case (tap_q)
					2'd0: begin
						pw = 26'(pa);
						kw = 12'sd768;
					end
					2'd1: begin
						pw = 26'(pb);
						kw = -12'sd1536;
					end
					default: begin
						pw = 26'(pc);
						kw = 12'sd768;
					end
				endcase
			end
			default: begin
				unique case (tap_q)
					2'd0: begin
						pw = 26'(pa);
						kw = 12'sd512 - fk;
					end
					2'd1: begin
						pw = 26'(pb);
						kw = 12'sd3 * fk - 12'sd1536;
					end
					2'd2: begin
						pw = 26'(pc);
						kw = 12'sd1536 - 12'sd3 * fk;
					end
					default: begin
						pw = 26'(pa);
						kw = fk + 12'sd256;
					end
				endcase
			end
		endcase
	end

	// one multiplier: weight build in WGT, sample times weight in MAC
	assign mul_a = (state_q == ST_MAC) ? weight_q : 30'(pw);
	assign mul_b = (state_q == ST_MAC) ? rdata_q : 16'(kw);
	assign mul_p = mul_a * mul_b;

	assign src      = cur_q.base + $signed({9'b0, tap_q});
	assign src_in   = !src[10] && (src[9:0] < {1'b0, cur_q.height});
	assign raddr    = src[7:0];
	assign last_tap = ({1'b0, tap_q} == cur_q.pts - 3'd1);

	// divide by 6*2^24: floor shift by 2^25, clamp, then times reciprocal of three
	assign rsum  = acc_q + HALF_DEN;
	assign tq    = rsum[47:25];
	assign dprod = {19'b0, u_q} * {18'b0, RECIP3};
	assign quo   = dprod[35:20];

	assign q_pop     = (state_q == ST_IDLE) && !qs.empty;
	assign mem_we    = q_pop && head.is_load;
	assign out_pop   = pop && out_valid_q;
	assign slot_free = !out_valid_q || out_pop;
	assign out_load  = (state_q == ST_OUT) && slot_free;

	assign empty         = !out_valid_q;
	assign shifted_value = out_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[head.row] <= head.sample;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tap_q       <= '0;
			cur_q       <= '0;
			weight_q    <= '0;
			acc_q       <= '0;
			inr_q       <= 1'b0;
			u_q         <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result may replace the one leaving in the same cycle
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						cur_q <= head;
						tap_q <= '0;
						acc_q <= '0;
						res_q <= '0;
						if (head.is_load || head.zero) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_WGT;
						end
					end
				end
				ST_WGT: begin
					weight_q <= mul_p[29:0];
					inr_q    <= src_in;
					state_q  <= ST_MAC;
				end
				ST_MAC: begin
					if (inr_q) begin
						acc_q <= acc_q + 48'(mul_p);
					end
					if (last_tap) begin
						state_q <= ST_RND;
					end else begin
						tap_q   <= tap_q + 2'd1;
						state_q <= ST_WGT;
					end
				end
				ST_RND: begin
					priority if (tq > T_HI) begin
						u_q <= U_MAX;
					end else if (tq < T_LO) begin
						u_q <= '0;
					end else begin
						u_q <= 18'(tq + T_OFF);
					end
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// quotient minus 32768 is the top bit flipped
					res_q   <= $signed({~quo[15], quo[14:0]});
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (slot_free) begin
						out_q   <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> design/lagrange_fractional_shift.sv
// top level of the lagrange fractional shift block: config registers, front, queue, back
//
// channel   | handshake                  | payload
// ----------+----------------------------+------------------------------------------------
// request   | push / full                | req_type, row_index, sample_value, kick_offset
// result    | empty / pop                | shifted_value
// config    | cfg_we (index cfg_index)   | cfg_data
//
// the front registers each request at its transfer and hands it on to a two-entry queue
// once the queue has room; the back pops one job at a time
// a load, like a compute that falls outside the column, goes from idle straight to output;
// a full compute has the shared multiplier alternate weight build and sample
// multiply-accumulate for each tap, then rounding and the divide by three
// the result sits in an output register, so new requests keep flowing into the queue
// while a result waits; full rises only when front stage and queue are both occupied
// arst_n clears control state and the config registers (4 points, height 256);
// the column store has no reset and holds garbage until written
`default_nettype none
module lagrange_fractional_shift
	import lfs_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic               req_type,
	input  wire logic        [7:0]  row_index,
	input  wire logic signed [15:0] sample_value,
	input  wire logic signed [15:0] kick_offset,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [15:0]      shifted_value,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic        [8:0]  cfg_data
);

	cfg_t    cfg_q;
	q_stat_t qs;
	logic    fr_push;
	job_t    fr_job;
	job_t    head;
	logic    q_pop;

	// configuration registers; the user must write them only while the block is quiet, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.points <= POINTS_RESET;
			cfg_q.height <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POINTS: cfg_q.points <= cfg_data[2:0];
				REG_HEIGHT: cfg_q.height <= cfg_data;
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	// front: position, base row, fraction, early-out classification
	lfs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.row_index    (row_index),
		.sample_value (sample_value),
		.kick_offset  (kick_offset),
		.qs           (qs),
		.fr_push      (fr_push),
		.fr_job       (fr_job)
	);

	// decoupling queue so front and back stall independently
	lfs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (fr_push),
		.wr_job (fr_job),
		.rd_en  (q_pop),
		.rd_job (head),
		.stat   (qs)
	);

	// back: store writes, tap sequencing, rounding, saturation, result register
	lfs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.qs            (qs),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.shifted_value (shifted_value)
	);

	// front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fr_push |-> !qs.full)
		else $error("job pushed into full queue");

	// back never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !qs.empty)
		else $error("job popped from empty queue");

	// the front stage never hands a job on while the queue is full
	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(qs.full && fr_push) |-> 1'b0)
		else $error("front stage moved while queue full");

endmodule
`default_nettype wire

>>> bench/tb_lagrange_fractional_shift.sv
// self-checking bench for the lagrange fractional shift block with random handshake gaps
`default_nettype none
module tb_lagrange_fractional_shift;
	import lfs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD = 10;
	localparam int WATCHDOG_LIMIT = 2000;
	// margin for a full cubic compute in the back, plus front stage and queue
	localparam int DRAIN_CYCLES = 24;
	localparam int PHASE_COUNT = 12;
	localparam int PHASE_ITEMS = 135;
	localparam int MAX_REPORTS = 40;

	// request kinds carried on req_type
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_COMPUTE = 1'b1;

	// point counts outside 1..4 that the block folds onto the nearest order
	localparam logic [2:0] PTS_ODD_ZERO = 3'd0;
	localparam logic [2:0] PTS_ODD_FIVE = 3'd5;
	localparam logic [2:0] PTS_ODD_SIX = 3'd6;
	localparam logic [2:0] PTS_ODD_SEVEN = 3'd7;

	localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
	localparam logic signed [15:0] KICK_MAX = 16'sh7FFF;
	localparam logic signed [15:0] KICK_MIN = 16'sh8000;

	// every weight is an integer numerator over 6 * 2^24
	localparam longint WEIGHT_DEN = 64'sd100663296;

	typedef struct {
		logic               kind;
		logic        [7:0]  row;
		logic signed [15:0] sample;
		logic signed [15:0] kick;
	} shift_req_t;

	// clock, reset and all block inputs start at known values
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic req_type = REQ_LOAD;
	logic [7:0] row_index = '0;
	logic signed [15:0] sample_value = '0;
	logic signed [15:0] kick_offset = '0;
	logic pop = 1'b1;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_POINTS;
	logic [8:0] cfg_data = '0;

	wire logic full;
	wire logic empty;
	wire logic signed [15:0] shifted_value;

	lagrange_fractional_shift dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.row_index    (row_index),
		.sample_value (sample_value),
		.kick_offset  (kick_offset),
		.empty        (empty),
		.pop          (pop),
		.shifted_value(shifted_value),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// mirror of the configuration registers, only changed while the block is idle
	logic [2:0] cfg_points = POINTS_RESET;
	logic [8:0] cfg_height = HEIGHT_RESET;

	// mirror of the column store, written as loads transfer
	logic signed [15:0] shift_store [MAX_HEIGHT];
	// rows already loaded by the time the stimulus is built, so no unwritten row is ever read
	bit row_written [MAX_HEIGHT];

	shift_req_t queued_requests [$];
	logic signed [15:0] expected_shifts [$];

	// handshake bookkeeping between the rising-edge monitor and the falling-edge drivers
	bit req_taken = 1'b0;
	bit req_held = 1'b0;
	bit res_taken = 1'b0;
	bit send_burst = 1'b0;
	bit recv_burst = 1'b0;
	int req_gap = 0;
	int res_gap = 0;
	shift_req_t cur_req;

	int mismatches = 0;
	int n_loads = 0;
	int n_computes = 0;
	int n_checked = 0;
	int n_settings = 0;
	int stall_cycles = 0;
	logic signed [15:0] want;

	int phase_points [PHASE_COUNT];
	int phase_height [PHASE_COUNT];

	// wait drawn for one transfer; now and then a stretch with no gaps at all
	function automatic int draw_gap(inout bit burst);
		if ($urandom_range(0, 39) == 0)
			burst = !burst;
		return burst ? 0 : int'($urandom_range(0, 14));
	endfunction

	// point count as the block uses it
	function automatic int eff_points();
		if (cfg_points == PTS_ODD_ZERO)
			return int'(PTS_NEAREST);
		if (cfg_points > PTS_CUBIC)
			return int'(PTS_CUBIC);
		return int'(cfg_points);
	endfunction

	// heights above the store depth are clamped
	function automatic int eff_height();
		return (cfg_height > HEIGHT_MAX) ? int'(HEIGHT_MAX) : int'(cfg_height);
	endfunction

	// base row and fraction of the shifted position; false when the result is forced to zero
	function automatic bit locate(input logic signed [15:0] kick, output int pts, output int h,
			output int jd, output int f);
		int p;
		pts = eff_points();
		h = eff_height();
		p = (h / 2) * 256 + int'(kick);
		jd = p / 256;
		f = p % 256;
		return (p >= 0) && (jd < h);
	endfunction

	function automatic int tap_row(input logic [7:0] row, input int jd, input int j,
			input int pts, input int h);
		return int'(row) + jd + j - (pts - 1) / 2 - h / 2;
	endfunction

	// interpolated output sample for one compute request
	function automatic logic signed [15:0] predict_shift(input logic [7:0] row,
			input logic signed [15:0] kick);
		int pts, h, jd, f, src;
		longint fl, acc, q;
		longint w [4];
		acc = 0;
		if (!locate(kick, pts, h, jd, f))
			return '0;
		fl = f;
		case (pts)
			PTS_NEAREST: begin
				w[0] = WEIGHT_DEN;
			end
			PTS_LINEAR: begin
				w[0] = (256 - fl) * 6 * 65536;
				w[1] = fl * 6 * 65536;
			end
			PTS_QUAD: begin
				w[0] = 768 * fl * (fl - 256);
				w[1] = 6 * 256 * (65536 - fl * fl);
				w[2] = 768 * fl * (fl + 256);
			end
			default: begin
				w[0] = -fl * (fl - 256) * (fl - 512);
				w[1] = 3 * (fl + 256) * (fl - 256) * (fl - 512);
				w[2] = 3 * (512 - fl) * fl * (fl + 256);
				w[3] = fl * (fl + 256) * (fl - 256);
			end
		endcase
		// taps that fall outside the column add nothing
		for (int j = 0; j < pts; j++) begin
			src = tap_row(row, jd, j, pts, h);
			if (src >= 0 && src < h)
				acc += longint'(shift_store[src]) * w[j];
		end
		// round half up, then saturate
		q = acc + WEIGHT_DEN / 2;
		q = (q >= 0) ? q / WEIGHT_DEN : -((-q + WEIGHT_DEN - 1) / WEIGHT_DEN);
		if (q > 32767)
			q = 32767;
		else if (q < -32768)
			q = -32768;
		return q[15:0];
	endfunction

	// stimulus builders
	task automatic add_load(input logic [7:0] row, input logic signed [15:0] value);
		shift_req_t r;
		r.kind = REQ_LOAD;
		r.row = row;
		r.sample = value;
		r.kick = 16'($urandom_range(0, 65535));
		row_written[row] = 1'b1;
		queued_requests.push_back(r);
	endtask

	// any in-column tap still unloaded gets a load first
	task automatic add_compute(input logic [7:0] row, input logic signed [15:0] kick);
		int pts, h, jd, f, src;
		shift_req_t r;
		if (locate(kick, pts, h, jd, f)) begin
			for (int j = 0; j < pts; j++) begin
				src = tap_row(row, jd, j, pts, h);
				if (src >= 0 && src < h && !row_written[src])
					add_load(src[7:0], 16'($urandom_range(0, 65535)));
			end
		end
		r.kind = REQ_COMPUTE;
		r.row = row;
		r.sample = 16'($urandom_range(0, 65535));
		r.kick = kick;
		queued_requests.push_back(r);
	endtask

	// rows mostly inside the column so that taps land on real data
	function automatic logic [7:0] pick_row();
		int eh;
		eh = eff_height();
		if ($urandom_range(0, 4) == 0 || eh >= 254)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, eh + 1));
	endfunction

	// kicks mostly around the usable window, with a share over the full range
	function automatic logic signed [15:0] pick_kick();
		int eh, lo, hi;
		eh = eff_height();
		lo = -(eh / 2) * 256 - 512;
		hi = (eh - eh / 2) * 256 + 512;
		if (lo < -32768)
			lo = -32768;
		if (hi > 32767)
			hi = 32767;
		if ($urandom_range(0, 6) == 0)
			return 16'($urandom_range(0, 65535));
		return 16'(lo + int'($urandom_range(0, hi - lo)));
	endfunction

	task automatic random_phase(input int n);
		repeat (n) begin
			if ($urandom_range(0, 99) < 35)
				add_load(pick_row(), 16'($urandom_range(0, 65535)));
			else
				add_compute(pick_row(), pick_kick());
		end
	endtask

	// block idle: nothing queued, nothing on the port, every result in, then a drain margin
	task automatic settle();
		while (queued_requests.size() != 0 || req_held || expected_shifts.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [8:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == REG_POINTS)
			cfg_points = value[2:0];
		else
			cfg_height = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// request driver: holds push until the transfer, then waits its drawn gap
	always @(negedge clk) begin
		if (req_taken) begin
			req_taken = 1'b0;
			req_held = 1'b0;
			req_gap = draw_gap(send_burst);
		end
		if (!req_held && queued_requests.size() != 0) begin
			if (req_gap > 0) begin
				req_gap--;
			end else begin
				cur_req = queued_requests.pop_front();
				req_held = 1'b1;
				req_type <= cur_req.kind;
				row_index <= cur_req.row;
				sample_value <= cur_req.sample;
				kick_offset <= cur_req.kick;
			end
		end
		push <= req_held;
	end

	// result side: pop stays high across back-to-back transfers unless a gap is drawn
	always @(negedge clk) begin
		if (res_taken) begin
			res_taken = 1'b0;
			res_gap = draw_gap(recv_burst);
		end
		if (res_gap > 0) begin
			res_gap--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// monitor: predicts on each request transfer, checks each result transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				if (req_type == REQ_LOAD) begin
					shift_store[row_index] = sample_value;
					expected_shifts.push_back('0);
					n_loads++;
				end else begin
					expected_shifts.push_back(predict_shift(row_index, kick_offset));
					n_computes++;
				end
				req_taken = 1'b1;
			end
			if (pop && !empty) begin
				if (expected_shifts.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t: result with none expected, shifted_value %0d",
							$time, shifted_value);
					mismatches++;
				end else begin
					want = expected_shifts.pop_front();
					if (shifted_value !== want) begin
						if (mismatches < MAX_REPORTS)
							$display("%0t: shifted_value mismatch, expected %0d actual %0d",
								$time, want, shifted_value);
						mismatches++;
					end
					n_checked++;
				end
				res_taken = 1'b1;
			end
			// watchdog on cycles without any transfer
			if ((push && !full) || (pop && !empty)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= WATCHDOG_LIMIT) begin
					$display("%0t: no transfer for %0d cycles", $time, stall_cycles);
					$display("[FAIL] regression broken");
					$finish;
				end
			end
		end
	end

	initial begin
		// settings walk: folded point counts, tiny, odd and oversized heights, back to reset values
		phase_points = '{PTS_NEAREST, PTS_LINEAR, PTS_QUAD, PTS_CUBIC, PTS_ODD_ZERO,
			PTS_ODD_FIVE, PTS_ODD_SEVEN, PTS_CUBIC, PTS_LINEAR, PTS_ODD_SIX, PTS_QUAD,
			POINTS_RESET};
		phase_height = '{256, 64, 2, 3, 511, 257, 17, 1, 0, 255, 100, HEIGHT_RESET};

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part under the reset settings (cubic, full height)
		add_load(8'd0, SAMPLE_MAX);
		add_load(8'd255, SAMPLE_MIN);
		add_load(8'd1, -16'sd1);
		add_load(8'd254, 16'sd1);
		// zero kick at both column edges, taps spill off each end
		add_compute(8'd0, 16'sd0);
		add_compute(8'd255, 16'sd0);
		// extreme kicks: position zero and the last base row
		add_compute(8'd0, KICK_MIN);
		add_compute(8'd255, KICK_MAX);
		add_compute(8'd128, KICK_MAX);
		add_compute(8'd128, KICK_MIN);
		// smallest and largest fraction
		add_compute(8'd64, 16'sd1);
		add_compute(8'd64, 16'sh00FF);
		// half-row kick with alternating extremes overshoots: positive saturation
		add_load(8'd127, SAMPLE_MIN);
		add_load(8'd128, SAMPLE_MAX);
		add_load(8'd129, SAMPLE_MAX);
		add_load(8'd130, SAMPLE_MIN);
		add_compute(8'd128, 16'sh0080);
		// and the mirror image for negative saturation
		add_load(8'd127, SAMPLE_MAX);
		add_load(8'd128, SAMPLE_MIN);
		add_load(8'd129, SAMPLE_MIN);
		add_load(8'd130, SAMPLE_MAX);
		add_compute(8'd128, 16'sh0080);
		settle();

		// random phases, registers rewritten only while idle
		for (int k = 0; k < PHASE_COUNT; k++) begin
			write_reg(REG_POINTS, 9'(phase_points[k]));
			write_reg(REG_HEIGHT, 9'(phase_height[k]));
			n_settings++;
			random_phase(PHASE_ITEMS);
			settle();
		end

		if (expected_shifts.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_shifts.size());
			mismatches++;
		end

		$display("covered %0d loads and %0d computes over %0d register settings",
			n_loads, n_computes, n_settings + 1);
		$display("%0d results compared, %0d mismatches", n_checked, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire
